>>> hw/rtl/dhkt_pkg.sv
// dhkt_pkg: shared types, constants and hash step functions for the key table.
// Used by dhkt_front, dhkt_fifo, dhkt_back, the top and the testbench; depends on nothing.
package dhkt_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int KEY_BYTES_DEF = 8;

    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_GET    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_ILLEGAL  = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    // classified request handed from the front to the back
    typedef struct packed {
        logic [1:0]  kind;
        logic        empty;
        logic [63:0] key;
        logic [31:0] data;
        logic [31:0] home;
        logic [31:0] step;
    } req_t;

    // one SDBM round: c + h*65599
    function automatic logic [31:0] sdbm_step(input logic [31:0] h, input logic [7:0] c);
        sdbm_step = {24'd0, c} + (h << 6) + (h << 16) - h;
    endfunction

    // one round of the step hash
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] x;
        x = h ^ {24'd0, c};
        fnv_step = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    endfunction

endpackage

>>> hw/rtl/dhkt_ram.sv
// dhkt_ram: generic single write port RAM with one registered read port.
// No dependencies.
module dhkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/dhkt_front.sv
// dhkt_front: accepts request words, trims the key and hashes it one byte per cycle.
// Depends on dhkt_pkg.
module dhkt_front #(
    parameter int KEY_BYTES = dhkt_pkg::KEY_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_kind,
    input  logic [63:0]     in_key,
    input  logic [31:0]     in_data,
    output logic            req_valid,
    input  logic            req_ready,
    output dhkt_pkg::req_t  req
);
    localparam int CW = $clog2(KEY_BYTES + 1);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_OUT} fstate_t;

    fstate_t        state_reg;
    logic [CW-1:0]  idx_reg;
    logic [63:0]    raw_reg;
    logic [63:0]    key_reg;
    logic [1:0]     kind_reg;
    logic [31:0]    data_reg, h1_reg, h2_reg;
    logic [7:0]     cur_byte;

    assign cur_byte  = raw_reg[7:0];
    assign in_ready  = (state_reg == F_IDLE);
    assign req_valid = (state_reg == F_OUT);

    always_comb begin
        req.kind  = kind_reg;
        req.empty = (key_reg == 64'd0);
        req.key   = key_reg;
        req.data  = data_reg;
        req.home  = h1_reg;
        req.step  = h2_reg;
    end

    // one key byte per cycle until the terminator or KEY_BYTES
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (in_valid) begin
                        raw_reg   <= in_key;
                        key_reg   <= 64'd0;
                        kind_reg  <= in_kind;
                        data_reg  <= in_data;
                        h1_reg    <= 32'd0;
                        h2_reg    <= 32'd0;
                        idx_reg   <= '0;
                        state_reg <= F_HASH;
                    end
                end
                F_HASH: begin
                    if (cur_byte == 8'd0 || idx_reg == CW'(KEY_BYTES)) begin
                        state_reg <= F_OUT;
                    end else begin
                        h1_reg  <= dhkt_pkg::sdbm_step(h1_reg, cur_byte);
                        h2_reg  <= dhkt_pkg::fnv_step(h2_reg, cur_byte);
                        key_reg <= key_reg | ({56'd0, cur_byte} << {idx_reg, 3'b000});
                        raw_reg <= raw_reg >> 8;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                F_OUT: begin
                    if (req_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/dhkt_fifo.sv
// dhkt_fifo: two-entry request queue between front and back.
// Depends on dhkt_pkg.
module dhkt_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  dhkt_pkg::req_t wr_req,
    output logic           rd_valid,
    input  logic           rd_ready,
    output dhkt_pkg::req_t rd_req
);
    dhkt_pkg::req_t ent_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_req   = ent_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= wr_req;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> hw/rtl/dhkt_back.sv
// dhkt_back: probe sequencer over the slot memories; reduces hashes, walks
// the probe chain, applies set/get/remove and holds the result word.
// Depends on dhkt_pkg and dhkt_ram.
module dhkt_back #(
    parameter int SLOTS = dhkt_pkg::SLOTS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    output logic           req_ready,
    input  dhkt_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [2:0]     res_status,
    output logic [31:0]    res_value,
    output logic [$clog2(SLOTS+1)-1:0] count_out
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // moduli and their rounded-down reciprocals, 2^32 / m
    localparam logic [31:0] MOD1 = 32'(SLOTS);
    localparam logic [31:0] MOD2 = 32'(SLOTS - 1);
    localparam logic [31:0] RCP1 = 32'((64'd1 << 32) / 64'(SLOTS));
    localparam logic [31:0] RCP2 = 32'((64'd1 << 32) / 64'(SLOTS - 1));

    // slot flag words {used, tombstone}
    localparam logic [1:0] FL_FREE = 2'b00;
    localparam logic [1:0] FL_LIVE = 2'b10;
    localparam logic [1:0] FL_TOMB = 2'b01;

    // hash reduction phases
    localparam logic [1:0] PH_QUO = 2'd0;
    localparam logic [1:0] PH_REM = 2'd1;

    typedef enum logic [2:0] {B_CLR, B_IDLE, B_MOD, B_RD, B_CHK, B_DONE} bstate_t;

    bstate_t         state_reg;
    dhkt_pkg::req_t  r_reg;
    logic [31:0]     h1_reg, h2_reg;        // hashes, then remainders
    logic [31:0]     q1_reg, q2_reg;        // quotient estimates
    logic [1:0]      ph_reg;
    logic [AW-1:0]   idx_reg, step_reg, free_reg, clr_reg;
    logic            got_free_reg;
    logic [CW-1:0]   probes_reg, count_reg;
    logic [2:0]      status_reg;
    logic [31:0]     value_reg;
    logic            kw, vw, fw;
    logic [AW-1:0]   waddr;
    logic [63:0]     kwdata, krd;
    logic [31:0]     vwdata, vrd;
    logic [1:0]      fwdata, frd;
    logic            f_used, f_tomb, hit, last_probe, ins;
    logic [AW:0]     nidx;
    logic [63:0]     p1, p2;
    logic [31:0]     h1_fix, h2_fix;

    assign req_ready  = (state_reg == B_IDLE);
    assign res_valid  = (state_reg == B_DONE);
    assign res_status = status_reg;
    assign res_value  = value_reg;
    assign count_out  = count_reg;

    dhkt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
        .aclk(aclk), .we(kw), .waddr(waddr), .wdata(kwdata), .raddr(idx_reg), .rdata(krd));
    dhkt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val (
        .aclk(aclk), .we(vw), .waddr(waddr), .wdata(vwdata), .raddr(idx_reg), .rdata(vrd));
    dhkt_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_flag (
        .aclk(aclk), .we(fw), .waddr(waddr), .wdata(fwdata), .raddr(idx_reg), .rdata(frd));

    assign f_used     = frd[1];
    assign f_tomb     = frd[0];
    assign hit        = f_used && (krd == r_reg.key);
    assign last_probe = (probes_reg == CW'(SLOTS - 1));
    // set that lands in a free slot on this probe
    assign ins = (r_reg.kind == dhkt_pkg::KIND_SET) &&
                 ((!f_used && !f_tomb) || (last_probe && (got_free_reg || !f_used)));

    // reciprocal reduction: estimate may be one short, fixed by one subtract
    assign p1     = {32'd0, h1_reg} * {32'd0, RCP1};
    assign p2     = {32'd0, h2_reg} * {32'd0, RCP2};
    assign h1_fix = (h1_reg >= MOD1) ? h1_reg - MOD1 : h1_reg;
    assign h2_fix = (h2_reg >= MOD2) ? h2_reg - MOD2 : h2_reg;
    assign nidx   = {1'b0, idx_reg} + {1'b0, step_reg};

    // memory write decode for the clearing pass and the check cycle
    always_comb begin
        kw = 1'b0;
        vw = 1'b0;
        fw = 1'b0;
        waddr  = idx_reg;
        kwdata = r_reg.key;
        vwdata = r_reg.data;
        fwdata = FL_FREE;
        if (state_reg == B_CLR) begin
            fw    = 1'b1;
            waddr = clr_reg;
        end else if (state_reg == B_CHK) begin
            if (hit) begin
                if (r_reg.kind == dhkt_pkg::KIND_SET) begin
                    vw = 1'b1;
                end else if (r_reg.kind == dhkt_pkg::KIND_REMOVE) begin
                    vw = 1'b1;
                    vwdata = 32'hFFFF_FFFE;
                    fw = 1'b1;
                    fwdata = FL_TOMB;
                end
            end else if (ins) begin
                kw = 1'b1;
                vw = 1'b1;
                fw = 1'b1;
                fwdata = FL_LIVE;
                waddr = got_free_reg ? free_reg : idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLR;
            clr_reg   <= '0;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                B_CLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(SLOTS - 1)) begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (req_valid) begin
                        r_reg        <= req;
                        h1_reg       <= req.home;
                        h2_reg       <= req.step;
                        ph_reg       <= PH_QUO;
                        got_free_reg <= 1'b0;
                        probes_reg   <= '0;
                        value_reg    <= 32'd0;
                        if (req.kind == dhkt_pkg::KIND_SET) begin
                            if (req.empty) begin
                                status_reg <= dhkt_pkg::ST_ILLEGAL;
                                state_reg  <= B_DONE;
                            end else if (count_reg == CW'(SLOTS)) begin
                                status_reg <= dhkt_pkg::ST_FULL;
                                state_reg  <= B_DONE;
                            end else begin
                                state_reg <= B_MOD;
                            end
                        end else if (req.kind == dhkt_pkg::KIND_GET ||
                                     req.kind == dhkt_pkg::KIND_REMOVE) begin
                            if (req.empty) begin
                                status_reg <= dhkt_pkg::ST_ABSENT;
                                value_reg  <= 32'hFFFF_FFFF;
                                state_reg  <= B_DONE;
                            end else begin
                                state_reg <= B_MOD;
                            end
                        end else begin
                            status_reg <= dhkt_pkg::ST_ILLEGAL;
                            state_reg  <= B_DONE;
                        end
                    end
                end
                B_MOD: begin
                    // quotient estimate, remainder, then home slot and step
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == PH_QUO) begin
                        q1_reg <= p1[63:32];
                        q2_reg <= p2[63:32];
                    end else if (ph_reg == PH_REM) begin
                        h1_reg <= h1_reg - q1_reg * MOD1;
                        h2_reg <= h2_reg - q2_reg * MOD2;
                    end else begin
                        idx_reg   <= AW'(h1_fix);
                        step_reg  <= AW'(h2_fix + 32'd1);
                        state_reg <= B_RD;
                    end
                end
                B_RD: begin
                    state_reg <= B_CHK;
                end
                B_CHK: begin
                    if (hit) begin
                        state_reg <= B_DONE;
                        if (r_reg.kind == dhkt_pkg::KIND_SET) begin
                            status_reg <= dhkt_pkg::ST_UPDATED;
                        end else if (r_reg.kind == dhkt_pkg::KIND_GET) begin
                            status_reg <= dhkt_pkg::ST_FOUND;
                            value_reg  <= vrd;
                        end else begin
                            status_reg <= dhkt_pkg::ST_REMOVED;
                            value_reg  <= vrd;
                            count_reg  <= count_reg - CW'(1);
                        end
                    end else if (!f_used && !f_tomb) begin
                        state_reg <= B_DONE;
                        if (r_reg.kind == dhkt_pkg::KIND_SET) begin
                            status_reg <= dhkt_pkg::ST_INSERTED;
                            count_reg  <= count_reg + CW'(1);
                        end else begin
                            status_reg <= dhkt_pkg::ST_ABSENT;
                            value_reg  <= 32'hFFFF_FFFF;
                        end
                    end else begin
                        if (!f_used && !got_free_reg) begin
                            got_free_reg <= 1'b1;
                            free_reg     <= idx_reg;
                        end
                        if (last_probe) begin
                            state_reg <= B_DONE;
                            if (r_reg.kind != dhkt_pkg::KIND_SET) begin
                                status_reg <= dhkt_pkg::ST_ABSENT;
                                value_reg  <= 32'hFFFF_FFFF;
                            end else if (got_free_reg || !f_used) begin
                                status_reg <= dhkt_pkg::ST_INSERTED;
                                count_reg  <= count_reg + CW'(1);
                            end else begin
                                status_reg <= dhkt_pkg::ST_FULL;
                            end
                        end else begin
                            probes_reg <= probes_reg + CW'(1);
                            idx_reg    <= (nidx >= (AW+1)'(SLOTS)) ?
                                          AW'(nidx - (AW+1)'(SLOTS)) : AW'(nidx);
                            state_reg  <= B_RD;
                        end
                    end
                end
                B_DONE: begin
                    if (res_ready) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/double_hash_key_table_top.sv
// Top level of the double-hashed key table: front, request queue and back.
// Depends on dhkt_pkg, dhkt_front, dhkt_fifo, dhkt_back, dhkt_ram.
//
// One result word per request word. After reset the back clears all SLOTS entries
// (64 by default) of the slot flag memory; request words are taken by the front
// meanwhile but not served. The front accepts the word, hashes the key byte by
// byte, sees the end of the key and hands the request to the queue. The back
// takes the request, reduces the two hashes (reciprocal multiply, remainder,
// final correction), then for each probe reads the memory and then compares and
// updates, up to SLOTS probes, and presents the result word. An empty key, an
// unknown kind or a set on a full table skips hashing and probing. Front and back
// run concurrently, so hashing of the next word overlaps the probe walk.
module double_hash_key_table_top #(
    parameter int SLOTS     = dhkt_pkg::SLOTS_DEF,
    parameter int KEY_BYTES = dhkt_pkg::KEY_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key[63:0], data[95:64]
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // value[31:0]
    output logic [2:0]   m_tuser    // status
);
    logic           f_valid, f_ready, b_valid, b_ready;
    dhkt_pkg::req_t f_req, b_req;
    logic [$clog2(SLOTS+1)-1:0] count;

    dhkt_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_kind(s_tuser), .in_key(s_tdata[63:0]), .in_data(s_tdata[95:64]),
        .req_valid(f_valid), .req_ready(f_ready), .req(f_req));

    dhkt_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_req(f_req),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_req(b_req));

    dhkt_back #(.SLOTS(SLOTS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(b_valid), .req_ready(b_ready), .req(b_req),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_status(m_tuser), .res_value(m_tdata), .count_out(count));

    // stored count never exceeds the table size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= ($clog2(SLOTS+1))'(SLOTS))
        else $error("stored count overflow");

    // an absent answer always carries -1
    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dhkt_pkg::ST_ABSENT |-> m_tdata == 32'hFFFF_FFFF)
        else $error("absent without -1");

    // full and illegal outcomes carry zero
    a_setzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dhkt_pkg::ST_FULL || m_tuser == dhkt_pkg::ST_ILLEGAL)
        |-> m_tdata == 32'd0)
        else $error("nonzero value on set result");
endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for double_hash_key_table_top.
// Depends on dhkt_pkg and the RTL of double_hash_key_table_top.
`timescale 1ns / 100ps

module tb_top;

    localparam int NSLOT = 64;
    localparam int NRAND = 1150;
    localparam logic [1:0] KIND_BAD = 2'd3;   // unknown request kind

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [31:0] data;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } rsp_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;   // key[63:0], data[95:64]
    logic [1:0]   s_tuser = '0;   // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;        // value[31:0]
    logic [2:0]   m_tuser;        // status

    double_hash_key_table_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // shadow table
    logic [63:0] tbl_key [NSLOT];
    logic [31:0] tbl_val [NSLOT];
    bit          tbl_used [NSLOT];
    bit          tbl_tomb [NSLOT];
    int          tbl_count;

    req_word_t   pending_q[$];
    rsp_word_t   expected_q[$];
    logic [63:0] key_pool[$];
    int          errors = 0;
    bit          hold_send = 0;
    bit          no_idle = 0;

    // strip bytes after the first zero byte, return length
    function automatic int trim_key(input logic [63:0] raw, output logic [63:0] k);
        int n;
        k = '0;
        for (n = 0; n < 8; n++) begin
            if (raw[8*n +: 8] == 8'd0) break;
            k[8*n +: 8] = raw[8*n +: 8];
        end
        return n;
    endfunction

    // probe walk: hit returns 1 with slot; else slot/has_room give insert point
    function automatic bit probe_table(input logic [63:0] k, input int n,
                                       output int slot, output bit has_room);
        logic [31:0] h1, h2, x;
        int idx, stp, free_idx;
        bit got_free;
        h1 = 0; h2 = 0; got_free = 0; free_idx = 0;
        for (int i = 0; i < n; i++) begin
            h1 = {24'd0, k[8*i +: 8]} + (h1 << 6) + (h1 << 16) - h1;
            x = h2 ^ {24'd0, k[8*i +: 8]};
            h2 = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
        end
        idx = h1 % NSLOT;
        stp = (h2 % (NSLOT - 1)) + 1;
        for (int p = 0; p < NSLOT; p++) begin
            if (p != 0) idx = (idx + stp) % NSLOT;
            if (tbl_used[idx]) begin
                if (tbl_key[idx] == k) begin
                    slot = idx; has_room = 0; return 1;
                end
            end else if (!tbl_tomb[idx]) begin
                slot = got_free ? free_idx : idx; has_room = 1; return 0;
            end else if (!got_free) begin
                got_free = 1; free_idx = idx;
            end
        end
        slot = free_idx; has_room = got_free;
        return 0;
    endfunction

    function automatic rsp_word_t table_access(input req_word_t r);
        rsp_word_t o;
        logic [63:0] k;
        int n, slot;
        bit room, hit;
        n = trim_key(r.key, k);
        o.status = dhkt_pkg::ST_ILLEGAL; o.value = 0;
        if (r.kind == dhkt_pkg::KIND_SET) begin
            if (n == 0) o.status = dhkt_pkg::ST_ILLEGAL;
            else if (tbl_count >= NSLOT) o.status = dhkt_pkg::ST_FULL;
            else begin
                hit = probe_table(k, n, slot, room);
                if (hit) begin
                    tbl_val[slot] = r.data; o.status = dhkt_pkg::ST_UPDATED;
                end else if (room) begin
                    tbl_key[slot] = k; tbl_val[slot] = r.data;
                    tbl_used[slot] = 1; tbl_tomb[slot] = 0;
                    tbl_count++; o.status = dhkt_pkg::ST_INSERTED;
                end else o.status = dhkt_pkg::ST_FULL;
            end
        end else if (r.kind == dhkt_pkg::KIND_GET || r.kind == dhkt_pkg::KIND_REMOVE) begin
            hit = (n != 0) && probe_table(k, n, slot, room);
            if (!hit) begin
                o.status = dhkt_pkg::ST_ABSENT; o.value = 32'hFFFF_FFFF;
            end else if (r.kind == dhkt_pkg::KIND_GET) begin
                o.status = dhkt_pkg::ST_FOUND; o.value = tbl_val[slot];
            end else begin
                o.status = dhkt_pkg::ST_REMOVED; o.value = tbl_val[slot];
                tbl_used[slot] = 0; tbl_tomb[slot] = 1;
                tbl_val[slot] = 32'hFFFF_FFFE;
                if (tbl_count > 0) tbl_count--;
            end
        end
        return o;
    endfunction

    function automatic req_word_t mk(input logic [1:0] kd, input logic [63:0] k,
                                     input logic [31:0] d);
        mk.kind = kd; mk.key = k; mk.data = d;
    endfunction

    // random key, mostly from a small pool so hits are common
    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        int len;
        if (key_pool.size() > 0 && $urandom_range(99) < 70)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        k = {$urandom, $urandom};
        len = $urandom_range(8, 1);
        for (int i = 0; i < 8; i++) begin
            if (i < len && k[8*i +: 8] == 8'd0) k[8*i +: 8] = 8'h5A;
            if (i == len && $urandom_range(1) == 0) k[8*i +: 8] = 8'd0;
        end
        if (len < 8 && k[8*len +: 8] != 8'd0) k[8*len +: 8] = 8'd0;
        if (key_pool.size() < 40) key_pool.push_back(k);
        return k;
    endfunction

    // record the input handshake at the rising edge
    bit s_tready_q = 0;
    always @(posedge aclk) s_tready_q <= s_tready;

    // driver: falling edge, one word per handshake
    bit sent_now;
    always @(negedge aclk) begin
        sent_now = s_tvalid && s_tready_q;
        if (sent_now) begin
            expected_q.push_back(table_access(pending_q.pop_front()));
        end
        if (!aresetn || hold_send) begin
            if (sent_now || !s_tvalid) s_tvalid <= 1'b0;
        end else if (sent_now || !s_tvalid) begin
            if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_q[0].kind;
                s_tdata  <= {pending_q[0].data, pending_q[0].key};
            end else begin
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom, $urandom, $urandom};
            end
        end
        m_tready <= aresetn && (no_idle || $urandom_range(99) >= 28);
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result word status=%0d value=%0d", m_tuser, m_tdata);
                errors++;
            end else begin
                rsp_word_t e;
                e = expected_q.pop_front();
                if (m_tuser !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_tuser);
                    errors++;
                end
                if (m_tdata !== e.value) begin
                    $error("value expected %0h actual %0h", e.value, m_tdata);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge aclk);
    endtask

    // stimulus
    initial begin
        logic [63:0] k;
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        // directed part
        pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'd0, 32'd5));
        pending_q.push_back(mk(dhkt_pkg::KIND_GET, 64'd0, 32'd0));
        pending_q.push_back(mk(dhkt_pkg::KIND_REMOVE, 64'h0000_0000_0000_0041, 32'd0));
        pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'h0000_0000_0000_0041, 32'h7FFF_FFFF));
        pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'h0000_0000_0000_0041, 32'h8000_0000));
        pending_q.push_back(mk(dhkt_pkg::KIND_GET, 64'hFF00_0000_0000_0041, 32'hFFFF_FFFF));
        pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        pending_q.push_back(mk(dhkt_pkg::KIND_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        pending_q.push_back(mk(dhkt_pkg::KIND_REMOVE, 64'h0000_0000_0000_0041, 32'd0));
        pending_q.push_back(mk(dhkt_pkg::KIND_GET, 64'h0000_0000_0000_0041, 32'd0));
        pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'h0000_0000_0000_0041, 32'd9));
        pending_q.push_back(mk(KIND_BAD, 64'h0000_0000_0000_0041, 32'd1));
        pending_q.push_back(mk(dhkt_pkg::KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        wait_drained();
        // fill until full, then probe full-table cases
        for (int i = 0; i < 70; i++)
            pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'h0100_0000_0000 | (i + 1), i));
        pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'h0100_0000_0000 | 1, 32'd77));
        pending_q.push_back(mk(dhkt_pkg::KIND_GET, 64'h0100_0000_0000 | 5, 32'd0));
        for (int i = 0; i < 64; i++)
            pending_q.push_back(mk(dhkt_pkg::KIND_REMOVE, 64'h0100_0000_0000 | (i + 1), 0));
        pending_q.push_back(mk(dhkt_pkg::KIND_SET, 64'h0200_0000_0000 | 3, 32'd3));
        // wait until everything has come back, then hold the sender off with hold_send
        wait_drained();
        hold_send = 1;
        repeat (50) @(posedge aclk);
        hold_send = 0;
        // random part, with no idling of sender or receiver in the middle stretch
        for (int i = 0; i < NRAND; i++) begin
            logic [1:0] kd;
            int r;
            if (i == 400) begin
                wait_drained(); no_idle = 1;
            end
            if (i == 600) begin
                wait_drained(); no_idle = 0;
            end
            r = $urandom_range(99);
            kd = r < 45 ? dhkt_pkg::KIND_SET : r < 75 ? dhkt_pkg::KIND_GET :
                 r < 98 ? dhkt_pkg::KIND_REMOVE : KIND_BAD;
            k = ($urandom_range(99) < 3) ? {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00
                                         : pick_key();
            pending_q.push_back(mk(kd, k, $urandom));
            if (pending_q.size() > 20) wait (pending_q.size() < 5);
        end
        wait_drained();
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dhkt_pkg.sv
hw/rtl/dhkt_ram.sv
hw/rtl/dhkt_front.sv
hw/rtl/dhkt_fifo.sv
hw/rtl/dhkt_back.sv
hw/rtl/double_hash_key_table_top.sv
tb/sv/tb_top.sv
